FILE: sv/srob_pkg.sv
// ----------------------------------------------------------------------------
// srob_pkg
// Shared types and constants of the sequence reorder buffer: window size,
// item and result layouts, codes and the slot store control bundle.
// ----------------------------------------------------------------------------
package srob_pkg;

  // window of held sequence numbers
  localparam int WINDOW = 16;
  localparam int SLOT_W = $clog2(WINDOW);

  // configuration port address width (three 32-bit registers)
  localparam int ADDR_W = 4;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  // operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // register indexes
  localparam logic [1:0] REG_FIRST_SEQ   = 2'd0;
  localparam logic [1:0] REG_MISS_THRESH = 2'd1;
  localparam logic [1:0] REG_TARGET      = 2'd2;

  // register reset values
  localparam logic [31:0] FIRST_SEQ_RST   = 32'd0;
  localparam logic [7:0]  MISS_THRESH_RST = 8'd3;
  localparam logic [15:0] TARGET_RST      = 16'd0;

  // pending counter saturation
  localparam logic [7:0] PEND_MAX = 8'hFF;

  // shared adder operations
  typedef enum logic [1:0] {
    ALU_SUB = 2'b01,
    ALU_INC = 2'b10
  } alu_op_t;

  typedef struct packed {
    logic        operation;
    logic        is_chat;
    logic [31:0] seq_number;
    logic [31:0] payload_tag;
  } srob_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] out_sequence;
    logic [31:0] out_tag;
    logic [15:0] out_target;
    logic        last;
  } srob_result_t;

  // slot store commands for one cycle
  typedef struct packed {
    logic        clr_all;
    logic        set;
    slot_idx_t   set_idx;
    logic [31:0] set_tag;
    logic        clr;
    slot_idx_t   clr_idx;
    slot_idx_t   rd_idx;
  } slot_ctl_t;

endpackage

FILE: sv/srob_alu.sv
// ----------------------------------------------------------------------------
// srob_alu
// Shared 32-bit adder: distance of an item from the expected number, and
// advance of the expected number during a delivery run.
// ----------------------------------------------------------------------------
module srob_alu (
  input  srob_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       y
);

  // subtract or increment, modulo 2^32
  always_comb begin
    unique case (op)
      srob_pkg::ALU_SUB: y = a - b;
      srob_pkg::ALU_INC: y = a + 32'd1;
      default:           y = a;
    endcase
  end

endmodule

FILE: sv/srob_slot_store.sv
// ----------------------------------------------------------------------------
// srob_slot_store
// Held items: one valid flag per slot in flip-flops and a tag memory with a
// single write port and a registered read port.
// ----------------------------------------------------------------------------
module srob_slot_store (
  input  logic                             clk,
  input  logic                             rst,
  input  srob_pkg::slot_ctl_t              ctl,
  output logic [srob_pkg::WINDOW-1:0]      valid,
  output logic [31:0]                      rd_tag
);

  logic [31:0] tag_mem [srob_pkg::WINDOW];

  // valid flags: clear all wins over set and release
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clr_all) begin
      valid <= '0;
    end else begin
      if (ctl.set) begin
        valid[ctl.set_idx] <= 1'b1;
      end
      if (ctl.clr) begin
        valid[ctl.clr_idx] <= 1'b0;
      end
    end
  end

  // tag memory, read data registered
  always_ff @(posedge clk) begin
    if (ctl.set) begin
      tag_mem[ctl.set_idx] <= ctl.set_tag;
    end
    rd_tag <= tag_mem[ctl.rd_idx];
  end

  // a clear leaves no slot held
  a_clr_all_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_all |=> valid == '0)
    else $error("slot store not empty after clear");

  // an item is only stored into a free slot
  a_set_free_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.set |-> !valid[ctl.set_idx])
    else $error("store into occupied slot");

  // only held slots are released
  a_clr_held_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.clr |-> valid[ctl.clr_idx])
    else $error("release of empty slot");

  // store and release never in the same cycle
  a_no_set_and_clr: assert property (@(posedge clk) disable iff (rst)
    !(ctl.set && ctl.clr))
    else $error("store and release together");

endmodule

FILE: sv/sequence_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Hold-back reorder buffer: holds chat items by sequence number in a window,
// delivers consecutive items in order and requests history when stuck.
// ----------------------------------------------------------------------------
// Flow: a stored add passes the lookup (S_LOOK) and read (S_READ) states, then
//   takes a delivery step (S_EMIT) per delivered item and a request step (S_REQ)
//   for a history request; a dropped add returns to idle after lookup; clear and
//   non-chat items are taken without leaving idle. No item is accepted while busy.
// The shared adder and the single read port of the tag memory set one delivery
//   per cycle. Results cannot be stalled by the receiver.
// Reset (rst, synchronous): registers to defaults, store empty, no sweep.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          start,
  input  srob_pkg::srob_item_t          item,
  output logic                          busy,
  // result channel
  output logic                          result_valid,
  output srob_pkg::srob_result_t        result,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srob_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_READ = 5'b00100,
    S_EMIT = 5'b01000,
    S_REQ  = 5'b10000
  } state_t;

  localparam logic [srob_pkg::SLOT_W:0] WINDOW_EXT =
    (srob_pkg::SLOT_W+1)'(srob_pkg::WINDOW);
  localparam srob_pkg::slot_idx_t LAST_SLOT =
    srob_pkg::SLOT_W'(srob_pkg::WINDOW - 1);

  state_t state, state_next;

  // configuration registers
  logic [31:0] first_sequence;
  logic [7:0]  missing_threshold;
  logic [15:0] delivery_target;

  // block state
  logic [31:0]         expected;
  srob_pkg::slot_idx_t head;
  logic [7:0]          pending;
  logic [31:0]         seq_r;
  logic [31:0]         tag_r;

  // datapath
  srob_pkg::alu_op_t          alu_op;
  logic [31:0]                alu_a;
  logic [31:0]                alu_y;
  logic                       in_window;
  logic [srob_pkg::SLOT_W:0]  slot_sum;
  srob_pkg::slot_idx_t        look_slot;
  srob_pkg::slot_idx_t        head_inc;
  logic                       head_ok;
  logic                       next_ok;
  logic                       last_deliver;
  logic                       accept;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;
  srob_pkg::slot_ctl_t        ctl;
  logic [srob_pkg::WINDOW-1:0] slot_valid;
  logic [31:0]                rd_tag;

  assign busy    = (state != S_IDLE);
  assign accept  = start && (state == S_IDLE);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[srob_pkg::ADDR_W-1:2];

  // shared adder: distance while looking up, increment while delivering
  assign alu_op = (state == S_EMIT) ? srob_pkg::ALU_INC : srob_pkg::ALU_SUB;
  assign alu_a  = (state == S_EMIT) ? expected : seq_r;

  srob_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (expected),
    .y  (alu_y)
  );

  // slot of the item: head plus distance, wrapped once
  assign in_window = (alu_y < 32'(srob_pkg::WINDOW));
  assign slot_sum  = {1'b0, head} + {1'b0, alu_y[srob_pkg::SLOT_W-1:0]};
  assign look_slot = (slot_sum >= WINDOW_EXT) ?
                     srob_pkg::SLOT_W'(slot_sum - WINDOW_EXT) :
                     slot_sum[srob_pkg::SLOT_W-1:0];

  // head pointer advance
  assign head_inc = (head == LAST_SLOT) ? '0 : head + srob_pkg::SLOT_W'(1);
  assign head_ok  = slot_valid[head];
  assign next_ok  = slot_valid[head_inc];

  // a delivery is last unless the run goes on or a request follows
  assign last_deliver = !next_ok && (missing_threshold != 8'd0);

  // slot store commands
  always_comb begin
    ctl.clr_all = (accept && (item.operation == srob_pkg::OP_CLEAR)) ||
                  (cfg_wr && (cfg_idx == srob_pkg::REG_FIRST_SEQ));
    ctl.set     = (state == S_LOOK) && in_window && !slot_valid[look_slot];
    ctl.set_idx = look_slot;
    ctl.set_tag = tag_r;
    ctl.clr     = (state == S_EMIT);
    ctl.clr_idx = head;
    ctl.rd_idx  = (state == S_EMIT) ? head_inc : head;
  end

  srob_slot_store u_store (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .valid  (slot_valid),
    .rd_tag (rd_tag)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (item.operation == srob_pkg::OP_ADD) && item.is_chat) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = ctl.set ? S_READ : S_IDLE;
      end
      S_READ: begin
        if (head_ok) begin
          state_next = S_EMIT;
        end else if (pending >= missing_threshold) begin
          state_next = S_REQ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (next_ok) begin
          state_next = S_EMIT;
        end else if (missing_threshold == 8'd0) begin
          state_next = S_REQ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_REQ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      expected          <= srob_pkg::FIRST_SEQ_RST;
      head              <= '0;
      pending           <= '0;
      first_sequence    <= srob_pkg::FIRST_SEQ_RST;
      missing_threshold <= srob_pkg::MISS_THRESH_RST;
      delivery_target   <= srob_pkg::TARGET_RST;
      result_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_EMIT) || (state == S_REQ);

      // register writes; a new first number empties the store
      if (cfg_wr) begin
        unique case (cfg_idx)
          srob_pkg::REG_FIRST_SEQ: begin
            first_sequence <= pwdata;
            expected       <= pwdata;
            head           <= '0;
          end
          srob_pkg::REG_MISS_THRESH: missing_threshold <= pwdata[7:0];
          srob_pkg::REG_TARGET:      delivery_target   <= pwdata[15:0];
          default: ;
        endcase
      end

      // clear item reloads the expected number
      if (accept && (item.operation == srob_pkg::OP_CLEAR)) begin
        expected <= first_sequence;
        head     <= '0;
      end

      // stored add counts, saturating
      if (ctl.set && (pending != srob_pkg::PEND_MAX)) begin
        pending <= pending + 8'd1;
      end

      // delivery advances the window
      if (state == S_EMIT) begin
        expected <= alu_y;
        head     <= head_inc;
        pending  <= '0;
      end

      if (state == S_REQ) begin
        pending <= '0;
      end
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r <= item.seq_number;
      tag_r <= item.payload_tag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      result.result_kind  <= srob_pkg::KIND_DELIVER;
      result.out_sequence <= expected;
      result.out_tag      <= rd_tag;
      result.out_target   <= delivery_target;
      result.last         <= last_deliver;
    end else if (state == S_REQ) begin
      result.result_kind  <= srob_pkg::KIND_REQUEST;
      result.out_sequence <= expected;
      result.out_tag      <= '0;
      result.out_target   <= delivery_target;
      result.last         <= 1'b1;
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      srob_pkg::REG_FIRST_SEQ:   prdata = first_sequence;
      srob_pkg::REG_MISS_THRESH: prdata = {24'd0, missing_threshold};
      srob_pkg::REG_TARGET:      prdata = {16'd0, delivery_target};
      default:                   prdata = '0;
    endcase
  end

  // results only come out of the delivery and request steps
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == S_EMIT) || ($past(state) == S_REQ))
    else $error("result without delivery or request step");

  // a request ends the run and carries no tag
  a_request_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == srob_pkg::KIND_REQUEST)
      |-> result.last && (result.out_tag == '0))
    else $error("malformed history request");

  // a result not marked last is followed by another
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |=> result_valid)
    else $error("run ended without last mark");

  // delivery only from a held head slot
  a_emit_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> slot_valid[head])
    else $error("delivery from empty head slot");

endmodule

FILE: dv/srob_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srob_checker
// Watches the item, result and register channels of the reorder buffer,
// keeps its own copy of the held window, predicts the results of every
// accepted item and compares each delivered result against the oldest one due.
// ----------------------------------------------------------------------------
module srob_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  srob_pkg::srob_item_t         item,
  input  logic                         result_valid,
  input  srob_pkg::srob_result_t       result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srob_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  input  logic [31:0]                  prdata,
  input  logic                         pready,
  output int                           mismatches,
  output int                           results_due
);

  // register shadows
  logic [31:0] first_seq;
  logic [7:0]  miss_thresh;
  logic [15:0] target;

  // held window
  logic                held      [srob_pkg::WINDOW];
  logic [31:0]         held_tag  [srob_pkg::WINDOW];
  logic [31:0]         next_seq;
  logic [7:0]          miss_count;
  srob_pkg::slot_idx_t head;

  srob_pkg::srob_result_t due_results[$];

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: mismatch on %s: got %h, want %h", what, got, want);
    mismatches = mismatches + 1;
  endtask

  task automatic empty_window();
    for (int i = 0; i < srob_pkg::WINDOW; i++) held[i] = 1'b0;
    next_seq = first_seq;
    head = '0;
  endtask

  function automatic srob_pkg::srob_result_t make_result(input logic kind,
                                                         input logic [31:0] seq,
                                                         input logic [31:0] tag);
    srob_pkg::srob_result_t r;
    r.result_kind  = kind;
    r.out_sequence = seq;
    r.out_tag      = tag;
    r.out_target   = target;
    r.last         = 1'b0;
    return r;
  endfunction

  // a clear empties the window, a stored add drains the run and may request history
  task automatic reorder_item(input srob_pkg::srob_item_t it);
    logic [31:0]            gap;
    srob_pkg::slot_idx_t    slot;
    srob_pkg::srob_result_t batch [srob_pkg::WINDOW+1];
    int                     n;
    n = 0;
    if (it.operation == srob_pkg::OP_CLEAR) begin
      empty_window();
    end else if (it.is_chat) begin
      gap  = it.seq_number - next_seq;
      slot = head + gap[srob_pkg::SLOT_W-1:0];
      if (gap < srob_pkg::WINDOW && !held[slot]) begin
        held[slot]     = 1'b1;
        held_tag[slot] = it.payload_tag;
        if (miss_count != srob_pkg::PEND_MAX) miss_count = miss_count + 1'b1;
        while (held[head] && n < srob_pkg::WINDOW) begin
          batch[n]   = make_result(srob_pkg::KIND_DELIVER, next_seq, held_tag[head]);
          n          = n + 1;
          held[head] = 1'b0;
          head       = head + 1'b1;
          next_seq   = next_seq + 1;
          miss_count = '0;
        end
        if (miss_count >= miss_thresh) begin
          batch[n]   = make_result(srob_pkg::KIND_REQUEST, next_seq, 32'd0);
          n          = n + 1;
          miss_count = '0;
        end
        if (n > 0) batch[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) due_results = {due_results, batch[i]};
      end
    end
  endtask

  always @(posedge clk) begin
    srob_pkg::srob_result_t want;
    if (rst) begin
      first_seq   = srob_pkg::FIRST_SEQ_RST;
      miss_thresh = srob_pkg::MISS_THRESH_RST;
      target      = srob_pkg::TARGET_RST;
      miss_count  = '0;
      mismatches  = 0;
      due_results.delete();
      empty_window();
    end else begin
      // results first, so an item accepted on the same edge cannot mask a stray result
      if (result_valid) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result, sequence", result.out_sequence, 32'd0);
        end else begin
          want = due_results.pop_front();
          if (result.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(result.result_kind),
                            32'(want.result_kind));
          if (result.out_sequence !== want.out_sequence)
            report_mismatch("out_sequence", result.out_sequence, want.out_sequence);
          if (result.out_tag !== want.out_tag)
            report_mismatch("out_tag", result.out_tag, want.out_tag);
          if (result.out_target !== want.out_target)
            report_mismatch("out_target", 32'(result.out_target), 32'(want.out_target));
          if (result.last !== want.last)
            report_mismatch("last", 32'(result.last), 32'(want.last));
        end
      end

      // register writes and read-back
      if (psel && penable && pready && pwrite) begin
        case (paddr[3:2])
          srob_pkg::REG_FIRST_SEQ: begin
            first_seq = pwdata;
            empty_window();
          end
          srob_pkg::REG_MISS_THRESH: miss_thresh = pwdata[7:0];
          srob_pkg::REG_TARGET:      target      = pwdata[15:0];
          default: ;
        endcase
      end else if (psel && penable && pready) begin
        case (paddr[3:2])
          srob_pkg::REG_FIRST_SEQ:
            if (prdata !== first_seq) report_mismatch("first_sequence read", prdata, first_seq);
          srob_pkg::REG_MISS_THRESH:
            if (prdata !== {24'd0, miss_thresh})
              report_mismatch("missing_threshold read", prdata, {24'd0, miss_thresh});
          srob_pkg::REG_TARGET:
            if (prdata !== {16'd0, target})
              report_mismatch("delivery_target read", prdata, {16'd0, target});
          default: ;
        endcase
      end

      if (start && !busy) reorder_item(item);
    end
    results_due <= due_results.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the reorder buffer with directed and random chat item streams over
// several register settings, with random gaps on the item side, and gives the
// verdict from the checker's mismatch count and a stall watchdog.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;

  logic                         clk;
  logic                         rst;
  logic                         start;
  srob_pkg::srob_item_t         item;
  logic                         busy;
  logic                         result_valid;
  srob_pkg::srob_result_t       result;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [srob_pkg::ADDR_W-1:0]  paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;
  int                           mismatches;
  int                           results_due;

  // stimulus state
  logic [31:0] first_cfg;
  logic [31:0] stream_base;
  bit          idling;
  int          stall_cycles;

  sequence_reorder_buffer u_top (
    .clk, .rst, .start, .item, .busy, .result_valid, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  srob_checker u_chk (
    .clk, .rst, .start, .busy, .item, .result_valid, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatches, .results_due
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog on cycles where nothing moves on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one item, start left high after accept so back-to-back items need no toggle
  task automatic send(input logic op, input logic chat, input logic [31:0] seq,
                      input logic [31:0] tag);
    srob_pkg::srob_item_t it;
    if (idling)
      while ($urandom_range(99) < 21) begin
        start <= 1'b0;
        @(posedge clk);
      end
    it.operation   = op;
    it.is_chat     = chat;
    it.seq_number  = seq;
    it.payload_tag = tag;
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // wait until every due result is out and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] first, input logic [7:0] thresh,
                            input logic [15:0] tgt);
    settle();
    reg_access(1'b1, srob_pkg::REG_FIRST_SEQ, first);
    reg_access(1'b1, srob_pkg::REG_MISS_THRESH, {24'($urandom_range(255, 0)), thresh});
    reg_access(1'b1, srob_pkg::REG_TARGET, {16'($urandom_range(65535, 0)), tgt});
    reg_access(1'b0, srob_pkg::REG_FIRST_SEQ, 32'd0);
    reg_access(1'b0, srob_pkg::REG_MISS_THRESH, 32'd0);
    reg_access(1'b0, srob_pkg::REG_TARGET, 32'd0);
    first_cfg   = first;
    stream_base = first;
  endtask

  // shuffled runs of consecutive numbers, with noise, duplicates and broken runs
  task automatic run_phase(input int quota);
    int          count;
    int          sz;
    int          omit;
    int          j;
    int          tmp;
    int          roll;
    int          perm [srob_pkg::WINDOW];
    bit          aborted;
    logic [31:0] seq;
    count = 0;
    while (count < quota) begin
      sz = ($urandom_range(9, 0) == 0) ? $urandom_range(srob_pkg::WINDOW, 9) :
                                         $urandom_range(6, 1);
      for (int i = 0; i < sz; i++) perm[i] = i;
      for (int i = sz - 1; i > 0; i--) begin
        j       = $urandom_range(i, 0);
        tmp     = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      omit    = (sz > 1 && $urandom_range(7, 0) == 0) ? $urandom_range(sz - 1, 0) : -1;
      aborted = 1'b0;
      for (int i = 0; i < sz && !aborted; i++) begin
        roll = $urandom_range(99, 0);
        if (roll < 8) begin
          send(srob_pkg::OP_ADD, 1'b0, $urandom, $urandom);
        end else if (roll < 13) begin
          seq = (i > 0) ? stream_base + perm[$urandom_range(i - 1, 0)] : stream_base - 1;
          send(srob_pkg::OP_ADD, 1'b1, seq, $urandom);
          count++;
        end else if (roll < 17) begin
          send(srob_pkg::OP_ADD, 1'b1, $urandom, $urandom);
          count++;
        end else if (roll < 19) begin
          send(srob_pkg::OP_CLEAR, 1'($urandom_range(1, 0)), $urandom, $urandom);
          stream_base = first_cfg;
          aborted     = 1'b1;
          count++;
        end
        if (!aborted && i != omit) begin
          send(srob_pkg::OP_ADD, 1'b1, stream_base + perm[i], $urandom);
          count++;
        end
      end
      // a run with a hole never drains, so restart the stream
      if (!aborted && omit >= 0) begin
        send(srob_pkg::OP_CLEAR, 1'($urandom_range(1, 0)), $urandom, $urandom);
        stream_base = first_cfg;
        count++;
      end else if (!aborted) begin
        stream_base = stream_base + sz;
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    item        = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idling      = 1'b1;
    first_cfg   = srob_pkg::FIRST_SEQ_RST;
    stream_base = srob_pkg::FIRST_SEQ_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: delivery, old, held duplicate, far, non-chat,
    // history request, drain of a run, clear
    send(srob_pkg::OP_ADD, 1'b1, 32'd0, 32'hFFFF_FFFF);
    send(srob_pkg::OP_ADD, 1'b1, 32'd0, 32'd0);
    send(srob_pkg::OP_ADD, 1'b1, 32'd2, $urandom);
    send(srob_pkg::OP_ADD, 1'b1, 32'd2, $urandom);
    send(srob_pkg::OP_ADD, 1'b1, 32'd3, 32'd0);
    send(srob_pkg::OP_ADD, 1'b1, 32'd17, $urandom);
    send(srob_pkg::OP_ADD, 1'b0, 32'd1, $urandom);
    send(srob_pkg::OP_ADD, 1'b1, 32'd5, $urandom);
    send(srob_pkg::OP_ADD, 1'b1, 32'd1, $urandom);
    send(srob_pkg::OP_CLEAR, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(srob_pkg::OP_ADD, 1'b1, 32'hFFFF_FFFF, $urandom);

    // directed, threshold zero across the 2^32 wrap: a full window in reverse
    set_config(32'hFFFF_FFF8, 8'd0, 16'hFFFF);
    for (int k = srob_pkg::WINDOW - 1; k >= 0; k--)
      send(srob_pkg::OP_ADD, 1'b1, 32'hFFFF_FFF8 + k, $urandom);

    // random phases over several settings
    set_config($urandom, 8'd1, 16'($urandom_range(65535, 0)));
    run_phase(45);
    idling = 1'b0;
    set_config(32'hFFFF_FFFF, 8'hFF, 16'h0000);
    run_phase(45);
    idling = 1'b1;
    set_config(32'd0, 8'($urandom_range(6, 2)), 16'hFFFF);
    run_phase(45);
    set_config($urandom, 8'd2, 16'($urandom_range(65535, 0)));
    reg_access(1'b1, REG_UNUSED, $urandom);
    run_phase(45);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
sv/srob_pkg.sv
sv/srob_alu.sv
sv/srob_slot_store.sv
sv/sequence_reorder_buffer.sv
dv/srob_checker.sv
dv/testbench.sv
